@@ rtl/sfcw_pkg.sv @@
// Package for the stereo FIR convolver: shared widths, register and request codes and
// the front-to-back queue entry type. No dependencies.
package sfcw_pkg;

    localparam int DEF_MAX_TAPS = 4096;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int SMP_W        = 16;
    localparam int TAP_W        = 18;
    localparam int TIDX_W       = 12;
    localparam int TCNT_W       = 13;
    localparam int GAIN_W       = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WET_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIX       = 2'd3;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TAP    = 1'b1;

    typedef struct packed {
        logic                     is_tap;
        logic signed [SMP_W-1:0]  left_sample;
        logic signed [SMP_W-1:0]  right_sample;
        logic [TIDX_W-1:0]        tap_index;
        logic signed [TAP_W-1:0]  tap_left;
        logic signed [TAP_W-1:0]  tap_right;
    } t_cmd;

endpackage

@@ rtl/sfcw_front.sv @@
// Front end: accepts transfers, drops out-of-range tap writes, and holds
// classified commands in a two-entry queue. Depends on sfcw_pkg.
module sfcw_front
    import sfcw_pkg::*;
#(
    parameter int MAX_TAPS = DEF_MAX_TAPS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_req_type,
    input  logic signed [SMP_W-1:0] i_left_sample,
    input  logic signed [SMP_W-1:0] i_right_sample,
    input  logic [TIDX_W-1:0]       i_tap_index,
    input  logic signed [TAP_W-1:0] i_tap_left,
    input  logic signed [TAP_W-1:0] i_tap_right,
    output logic                    o_cmd_valid,
    output t_cmd                    o_cmd,
    input  logic                    i_cmd_take
);
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_acc, w_keep;
    t_cmd       w_cmd;

    assign o_stall     = (r_cnt == 2'd2);
    assign w_acc       = i_valid && !o_stall;
    // Tap writes beyond the tap memory are dropped here.
    assign w_keep      = (i_req_type == REQ_SAMPLE) ||
                         ({20'd0, i_tap_index} < 32'(MAX_TAPS));
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        w_cmd.is_tap       = (i_req_type == REQ_TAP);
        w_cmd.left_sample  = i_left_sample;
        w_cmd.right_sample = i_right_sample;
        w_cmd.tap_index    = i_tap_index;
        w_cmd.tap_left     = i_tap_left;
        w_cmd.tap_right    = i_tap_right;
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_keep) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_acc && w_keep) r_wp <= ~r_wp;
            if (i_cmd_take) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'((w_acc && w_keep) ? 1 : 0) - 2'(i_cmd_take ? 1 : 0);
        end
    end

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_take |-> o_cmd_valid) else $error("queue read while empty");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> o_stall) else $error("full queue not stalling");
endmodule

@@ rtl/sfcw_back.sv @@
// Back end: history and tap memories, a serial multiply-accumulate over the
// taps, then a post-processing sequencer and an output register. Depends on sfcw_pkg.
module sfcw_back
    import sfcw_pkg::*;
#(
    parameter int MAX_TAPS = DEF_MAX_TAPS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [TCNT_W-1:0]       i_tap_count,
    input  logic [GAIN_W-1:0]       i_wet_gain,
    input  logic [GAIN_W-1:0]       i_stereo_width,
    input  logic [GAIN_W-1:0]       i_mix_level,
    input  logic                    i_cmd_valid,
    input  t_cmd                    i_cmd,
    output logic                    o_cmd_take,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [SMP_W-1:0] o_left_out,
    output logic signed [SMP_W-1:0] o_right_out
);
    localparam int AW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW  = $clog2(MAX_TAPS + 1) + 1;
    localparam int ACW = 34 + CW;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_MAC   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_GAIN  = 3'd4;
    localparam logic [2:0] ST_WIDTH = 3'd5;
    localparam logic [2:0] ST_MIX   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic signed [SMP_W-1:0] r_hl [MAX_TAPS];
    logic signed [SMP_W-1:0] r_hr [MAX_TAPS];
    logic signed [TAP_W-1:0] r_tl [MAX_TAPS];
    logic signed [TAP_W-1:0] r_tr [MAX_TAPS];

    logic [2:0]    r_st, n_st;
    logic [AW-1:0] r_pos, r_haddr, r_clr;
    logic [CW-1:0] r_k, r_n;
    logic          r_rd_v, r_rd_v2;
    logic signed [SMP_W-1:0] r_hld, r_hrd;
    logic signed [TAP_W-1:0] r_tld, r_trd;
    logic signed [SMP_W+TAP_W-1:0] r_pl, r_pr;
    logic signed [ACW-1:0] r_accl, r_accr;
    logic signed [47:0] r_l, r_r, r_a, r_b;
    logic signed [SMP_W-1:0] r_lo, r_ro;
    logic          r_ov;

    function automatic logic signed [47:0] rnd(input logic signed [79:0] v, input int sh);
        logic signed [79:0] t;
        t = (v + (80'sd1 <<< (sh - 1))) >>> sh;
        return t[47:0];
    endfunction

    function automatic logic signed [SMP_W-1:0] sat(input logic signed [47:0] v);
        logic signed [SMP_W-1:0] s;
        if (v > 48'sd32767) s = 16'sh7fff;
        else if (v < -48'sd32768) s = 16'sh8000;
        else s = v[SMP_W-1:0];
        return s;
    endfunction

    logic [AW-1:0] w_newpos;
    assign w_newpos = (32'(r_pos) + 1 == MAX_TAPS) ? '0 : r_pos + AW'(1);

    assign o_cmd_take  = (r_st == ST_IDLE) && i_cmd_valid && !(r_ov && !i_cmd.is_tap);
    assign o_valid     = r_ov;
    assign o_left_out  = r_lo;
    assign o_right_out = r_ro;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_CLEAR: if (32'(r_clr) == MAX_TAPS - 1) n_st = ST_IDLE;
            ST_IDLE:  if (o_cmd_take && !i_cmd.is_tap) n_st = ST_MAC;
            ST_MAC:   if (r_k == r_n) n_st = ST_DRAIN;
            ST_DRAIN: if (!r_rd_v && !r_rd_v2) n_st = ST_GAIN;
            ST_GAIN:  n_st = ST_WIDTH;
            ST_WIDTH: n_st = ST_MIX;
            ST_MIX:   n_st = ST_OUT;
            ST_OUT:   n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    // Memories: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (r_st == ST_CLEAR) begin
            r_hl[r_clr] <= '0;
            r_hr[r_clr] <= '0;
        end else if (o_cmd_take && !i_cmd.is_tap) begin
            r_hl[w_newpos] <= i_cmd.left_sample;
            r_hr[w_newpos] <= i_cmd.right_sample;
        end
        if (o_cmd_take && i_cmd.is_tap) begin
            r_tl[i_cmd.tap_index[AW-1:0]] <= i_cmd.tap_left;
            r_tr[i_cmd.tap_index[AW-1:0]] <= i_cmd.tap_right;
        end
        r_hld <= r_hl[r_haddr];
        r_hrd <= r_hr[r_haddr];
        r_tld <= r_tl[r_k[AW-1:0]];
        r_trd <= r_tr[r_k[AW-1:0]];
        r_pl  <= r_hld * r_tld;
        r_pr  <= r_hrd * r_trd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_CLEAR;
            r_clr   <= '0;
            r_pos   <= '0;
            r_ov    <= 1'b0;
            r_rd_v  <= 1'b0;
            r_rd_v2 <= 1'b0;
            r_k     <= '0;
            r_n     <= '0;
            r_haddr <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == ST_CLEAR) r_clr <= r_clr + AW'(1);
            if (r_ov && !i_stall) r_ov <= 1'b0;
            r_rd_v  <= (r_st == ST_MAC) && (r_k != r_n);
            r_rd_v2 <= r_rd_v;
            if (o_cmd_take && !i_cmd.is_tap) begin
                r_pos   <= w_newpos;
                r_haddr <= w_newpos;
                r_k     <= '0;
                r_n     <= ({19'd0, i_tap_count} > 32'(MAX_TAPS)) ?
                           CW'(MAX_TAPS) : CW'(i_tap_count);
                r_accl  <= '0;
                r_accr  <= '0;
            end
            if (r_st == ST_MAC && r_k != r_n) begin
                r_k     <= r_k + CW'(1);
                r_haddr <= (r_haddr == '0) ? AW'(MAX_TAPS - 1) : r_haddr - AW'(1);
            end
            if (r_rd_v2) begin
                r_accl <= r_accl + ACW'(r_pl);
                r_accr <= r_accr + ACW'(r_pr);
            end
            if (r_st == ST_GAIN) begin
                r_l <= rnd(80'(rnd(80'(r_accl), 8)) * $signed({1'b0, i_wet_gain}), 14);
                r_r <= rnd(80'(rnd(80'(r_accr), 8)) * $signed({1'b0, i_wet_gain}), 14);
            end
            if (r_st == ST_WIDTH) begin
                r_a <= r_l + r_r;
                r_b <= rnd(80'(r_l - r_r) * $signed({1'b0, i_stereo_width}), 15);
            end
            if (r_st == ST_MIX) begin
                r_lo <= sat(rnd(80'(r_a + r_b) * $signed({1'b0, i_mix_level}), 24));
                r_ro <= sat(rnd(80'(r_a - r_b) * $signed({1'b0, i_mix_level}), 24));
            end
            if (r_st == ST_OUT) r_ov <= 1'b1;
        end
    end

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |-> (r_st == ST_IDLE)) else $error("command taken while busy");
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_MAC) |-> (r_k <= r_n)) else $error("tap counter overran");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_OUT) |-> (!r_ov || !i_stall) || !r_ov) else $error("bad out");
endmodule

@@ rtl/stereo_fir_convolver_width_mix.sv @@
// Stereo direct-form FIR convolver with wet gain, mid/side width and mix.
// Each sample runs through a serial multiply-accumulate over tap_count taps,
// one MAC per channel, then the gain, width and mix steps and the output register;
// the next sample is taken only once the last result has left the output register.
// Reset is synchronous, active low; after reset the history memories are cleared.
// Depends on sfcw_pkg, sfcw_front and sfcw_back.
module stereo_fir_convolver_width_mix
    import sfcw_pkg::*;
#(
    parameter int MAX_TAPS = DEF_MAX_TAPS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_req_type,
    input  logic signed [SMP_W-1:0] i_left_sample,
    input  logic signed [SMP_W-1:0] i_right_sample,
    input  logic [TIDX_W-1:0]       i_tap_index,
    input  logic signed [TAP_W-1:0] i_tap_left,
    input  logic signed [TAP_W-1:0] i_tap_right,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [SMP_W-1:0] o_left_out,
    output logic signed [SMP_W-1:0] o_right_out
);
    // Configuration registers; user writes only while the block is idle, unenforced.
    logic [TCNT_W-1:0] r_tap_count;
    logic [GAIN_W-1:0] r_wet_gain, r_width, r_mix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= '0;
            r_wet_gain  <= 16'd16384;
            r_width     <= 16'd16384;
            r_mix       <= 16'd16384;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TAP_COUNT: r_tap_count <= i_cfg_data[TCNT_W-1:0];
                REG_WET_GAIN:  r_wet_gain  <= i_cfg_data;
                REG_WIDTH:     r_width     <= i_cfg_data;
                REG_MIX:       r_mix       <= i_cfg_data;
                default:       r_mix       <= r_mix;
            endcase
        end
    end

    // The queue between front and back lets input transfers land while a
    // result waits on the output register.
    logic cmd_valid, cmd_take;
    t_cmd cmd;

    sfcw_front #(.MAX_TAPS(MAX_TAPS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_req_type, .i_left_sample,
        .i_right_sample, .i_tap_index, .i_tap_left, .i_tap_right,
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_take(cmd_take)
    );

    sfcw_back #(.MAX_TAPS(MAX_TAPS)) u_back (
        .i_clk, .i_rst_n, .i_tap_count(r_tap_count), .i_wet_gain(r_wet_gain),
        .i_stereo_width(r_width), .i_mix_level(r_mix),
        .i_cmd_valid(cmd_valid), .i_cmd(cmd), .o_cmd_take(cmd_take),
        .o_valid, .i_stall, .o_left_out, .o_right_out
    );
endmodule

@@ tb/sfcw_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the stereo FIR convolver: watches the config port and both
// channels, predicts each sample result and compares it. Depends on sfcw_pkg.
module sfcw_checker
    import sfcw_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_valid,
    input  logic                    i_in_stall,
    input  logic                    i_req_type,
    input  logic signed [SMP_W-1:0] i_left_sample,
    input  logic signed [SMP_W-1:0] i_right_sample,
    input  logic [TIDX_W-1:0]       i_tap_index,
    input  logic signed [TAP_W-1:0] i_tap_left,
    input  logic signed [TAP_W-1:0] i_tap_right,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic signed [SMP_W-1:0] i_left_out,
    input  logic signed [SMP_W-1:0] i_right_out,
    output int                      o_errors,
    output int                      o_pending
);

    typedef struct {
        logic signed [SMP_W-1:0] left;
        logic signed [SMP_W-1:0] right;
    } t_stereo;

    t_stereo                 expected_q[$];
    logic signed [SMP_W-1:0] hist_l[DEF_MAX_TAPS];
    logic signed [SMP_W-1:0] hist_r[DEF_MAX_TAPS];
    logic signed [TAP_W-1:0] coef_l[DEF_MAX_TAPS];
    logic signed [TAP_W-1:0] coef_r[DEF_MAX_TAPS];
    logic [TIDX_W-1:0]       newest;
    logic [TCNT_W-1:0]       tap_count;
    logic [GAIN_W-1:0]       wet_gain;
    logic [GAIN_W-1:0]       width;
    logic [GAIN_W-1:0]       mix;

    initial o_errors = 0;

    // Round half up: arithmetic shift of v plus half an output unit.
    function automatic longint round_sh(longint v, int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [SMP_W-1:0] clip16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[SMP_W-1:0];
    endfunction

    // Push one stereo pair into the history and work out its output pair.
    function t_stereo filter_pair(logic signed [SMP_W-1:0] ls, logic signed [SMP_W-1:0] rs);
        longint  acc_l, acc_r, mid2, side2, sw;
        int      n;
        t_stereo res;
        newest = newest + 1'b1;
        hist_l[newest] = ls;
        hist_r[newest] = rs;
        n = (tap_count > DEF_MAX_TAPS) ? DEF_MAX_TAPS : int'(tap_count);
        acc_l = 0;
        acc_r = 0;
        for (int k = 0; k < n; k++) begin
            acc_l += longint'(hist_l[TIDX_W'(newest - k)]) * longint'(coef_l[k]);
            acc_r += longint'(hist_r[TIDX_W'(newest - k)]) * longint'(coef_r[k]);
        end
        acc_l = round_sh(round_sh(acc_l, 8) * longint'(wet_gain), 14);
        acc_r = round_sh(round_sh(acc_r, 8) * longint'(wet_gain), 14);
        mid2  = acc_l + acc_r;
        side2 = acc_l - acc_r;
        sw    = round_sh(side2 * longint'(width), 15);
        res.left  = clip16(round_sh((mid2 + sw) * longint'(mix), 24));
        res.right = clip16(round_sh((mid2 - sw) * longint'(mix), 24));
        return res;
    endfunction

    task report_mismatch(string what, int got, int exp);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, exp);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_stereo want;
        if (!i_rst_n) begin
            expected_q.delete();
            for (int i = 0; i < DEF_MAX_TAPS; i++) begin
                hist_l[i] = '0;
                hist_r[i] = '0;
                coef_l[i] = '0;
                coef_r[i] = '0;
            end
            newest    = '0;
            tap_count = '0;
            wet_gain  = 16'd16384;
            width     = 16'd16384;
            mix       = 16'd16384;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TAP_COUNT: tap_count = i_cfg_data[TCNT_W-1:0];
                    REG_WET_GAIN:  wet_gain  = i_cfg_data;
                    REG_WIDTH:     width     = i_cfg_data;
                    REG_MIX:       mix       = i_cfg_data;
                endcase
            end
            if (i_valid && !i_in_stall) begin
                if (i_req_type == REQ_TAP) begin
                    coef_l[i_tap_index] = i_tap_left;
                    coef_r[i_tap_index] = i_tap_right;
                end else begin
                    expected_q.push_back(filter_pair(i_left_sample, i_right_sample));
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected output transfer", 0, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (i_left_out !== want.left)
                        report_mismatch("left_out", i_left_out, want.left);
                    if (i_right_out !== want.right)
                        report_mismatch("right_out", i_right_out, want.right);
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Top of the convolver testbench: clock, reset, stimulus and verdict.
// Depends on sfcw_pkg, stereo_fir_convolver_width_mix and sfcw_checker.
module tb;
    import sfcw_pkg::*;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    i_valid;
    logic                    o_stall;
    logic                    i_req_type;
    logic signed [SMP_W-1:0] i_left_sample;
    logic signed [SMP_W-1:0] i_right_sample;
    logic [TIDX_W-1:0]       i_tap_index;
    logic signed [TAP_W-1:0] i_tap_left;
    logic signed [TAP_W-1:0] i_tap_right;
    logic                    o_valid;
    logic                    i_stall;
    logic signed [SMP_W-1:0] o_left_out;
    logic signed [SMP_W-1:0] o_right_out;

    int errors;
    int pending;
    int send_idle_pct;     // chance per cycle that the sender idles before an item
    int recv_stall_pct;    // chance per cycle that the receiver stalls
    bit hold_off;          // forces a long receiver stall when set
    int cur_taps;          // tap_count as last written, for the drain delay
    int samples_sent;
    int taps_sent;

    stereo_fir_convolver_width_mix dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_tap_index    (i_tap_index),
        .i_tap_left     (i_tap_left),
        .i_tap_right    (i_tap_right),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_left_out     (o_left_out),
        .o_right_out    (o_right_out)
    );

    sfcw_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .i_in_stall     (o_stall),
        .i_req_type     (i_req_type),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_tap_index    (i_tap_index),
        .i_tap_left     (i_tap_left),
        .i_tap_right    (i_tap_right),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_left_out     (o_left_out),
        .i_right_out    (o_right_out),
        .o_errors       (errors),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The slowest correct run, counting the history clear after reset, ends well
    // before this timeout.
    initial begin
        #20ms;
        $display("Timeout: the run did not finish");
        $display("Some tests failed");
        $finish;
    end

    // Receiver: random stalls at the current rate, or a solid stall while a
    // hold-off is in progress. One assignment per clock edge.
    initial begin
        i_stall = 1'b1;
        forever begin
            @(posedge i_clk);
            i_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Offer one item and keep it steady until the block takes it. The stall
    // is sampled at the falling edge, so the decision never races the edge.
    task automatic offer(logic req, logic signed [SMP_W-1:0] ls, logic signed [SMP_W-1:0] rs,
                         logic [TIDX_W-1:0] idx, logic signed [TAP_W-1:0] tl,
                         logic signed [TAP_W-1:0] tr);
        bit taken;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_req_type     <= req;
        i_left_sample  <= ls;
        i_right_sample <= rs;
        i_tap_index    <= idx;
        i_tap_left     <= tl;
        i_tap_right    <= tr;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        if (req == REQ_TAP) taps_sent++;
        else samples_sent++;
    endtask

    // Sample transfers carry random junk in the tap fields, and the other way round.
    task automatic send_sample(logic signed [SMP_W-1:0] ls, logic signed [SMP_W-1:0] rs);
        offer(REQ_SAMPLE, ls, rs, TIDX_W'($urandom), TAP_W'($urandom), TAP_W'($urandom));
    endtask

    task automatic send_tap(logic [TIDX_W-1:0] idx, logic signed [TAP_W-1:0] tl,
                            logic signed [TAP_W-1:0] tr);
        offer(REQ_TAP, SMP_W'($urandom), SMP_W'($urandom), idx, tl, tr);
    endtask

    // Stop offering, wait for every expected result, then give the block
    // its full processing time, since a trailing tap write produces nothing.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (cur_taps + 40) @(posedge i_clk);
    endtask

    // Write all four registers back to back; only called with the block idle.
    task automatic set_regs(int taps, int gain, int wid, int mixv);
        logic [CFG_IDX_W-1:0]  idx_list[4];
        logic [CFG_DATA_W-1:0] val_list[4];
        idx_list = '{REG_TAP_COUNT, REG_WET_GAIN, REG_WIDTH, REG_MIX};
        val_list = '{CFG_DATA_W'(taps), CFG_DATA_W'(gain), CFG_DATA_W'(wid), CFG_DATA_W'(mixv)};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx_list[i];
            i_cfg_data <= val_list[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cur_taps = (taps > DEF_MAX_TAPS) ? DEF_MAX_TAPS : taps;
    endtask

    // Random traffic: mostly samples, with tap rewrites among the first 16
    // positions and now and then anywhere, so every index bit toggles.
    task automatic random_traffic(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(3) == 0)
                send_tap(($urandom_range(3) == 0) ? TIDX_W'($urandom) : TIDX_W'($urandom_range(15)),
                         TAP_W'($urandom), TAP_W'($urandom));
            else
                send_sample(SMP_W'($urandom), SMP_W'($urandom));
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_req_type     = REQ_SAMPLE;
        i_left_sample  = '0;
        i_right_sample = '0;
        i_tap_index    = '0;
        i_tap_left     = '0;
        i_tap_right    = '0;
        hold_off       = 1'b0;
        send_idle_pct  = 21;
        recv_stall_pct = 83;
        cur_taps       = 0;
        samples_sent   = 0;
        taps_sent      = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. With reset settings there are no taps, so the
        // first samples must come out as zero.
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh8000, 16'sh7fff);
        // Fill the first 16 taps: extremes first, then random values.
        send_tap(12'd0, 18'sh1ffff, 18'sh20000);
        send_tap(12'd1, 18'sh20000, 18'sh1ffff);
        send_tap(12'd2, 18'sh00000, 18'sh3ffff);
        send_tap(12'd3, 18'sh3ffff, 18'sh00001);
        for (int i = 4; i < 16; i++)
            send_tap(TIDX_W'(i), TAP_W'($urandom), TAP_W'($urandom));
        drain();
        set_regs(4, 16384, 16384, 16384);
        send_sample(16'sh7fff, 16'sh7fff);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sh0000, 16'shffff);
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh8000, 16'sh7fff);
        // A write to the top tap position while samples stream.
        send_tap(12'hfff, 18'sh1ffff, 18'sh20000);
        send_sample(16'sh0001, 16'sh8000);
        drain();

        // Phase one: lazy receiver, zero stereo width, mix set to 32768.
        set_regs($urandom_range(1, 16), 32768, 0, 32768);
        random_traffic(40);
        drain();

        // Phase two: lazy sender, and a long receiver hold-off while the
        // sender keeps offering, so the block backs up and stalls its input.
        send_idle_pct  = 83;
        recv_stall_pct = 21;
        set_regs($urandom_range(1, 16), $urandom_range(65535), 32768, 65535);
        fork
            begin
                @(negedge i_clk);
                hold_off = 1'b1;
                repeat (400) @(negedge i_clk);
                hold_off = 1'b0;
            end
        join_none
        send_idle_pct = 0;
        random_traffic(15);
        send_idle_pct = 83;
        random_traffic(25);
        drain();

        // Phase three: no idling at all, oversized gain and width to saturate.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_regs($urandom_range(1, 16), 65535, 65535, $urandom_range(65535));
        random_traffic(30);
        drain();
        set_regs(16, 0, $urandom_range(65535), 0);
        random_traffic(6);
        drain();
        set_regs($urandom_range(0, 16), $urandom_range(65535), $urandom_range(65535),
                 $urandom_range(65535));
        random_traffic(12);
        drain();

        $display("Covered %0d sample and %0d tap transfers over several register settings,",
                 samples_sent, taps_sent);
        $display("with random idling on both sides, a long output hold-off and saturation.");
        if (errors == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
